@@ rtl/core/spa_pkg.sv @@
`default_nettype none

package spa_pkg;

  // default sizing
  localparam int DEF_MAX_CORES        = 32;
  localparam int DEF_POOL_SLOTS       = 64;
  localparam int DEF_CORES_PER_SHARED = 4;

  // fixed field widths
  localparam int CFG_W    = 6;
  localparam int CORE_W   = 5;
  localparam int FPOOL_W  = 3;
  localparam int SLOT_W   = 6;
  localparam int HPOOL_W  = 5;
  localparam int STATUS_W = 3;
  localparam int CIN_W    = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOT_LOCAL    = 3'd0,
    ST_GOT_GLOBAL   = 3'd1,
    ST_EXHAUSTED    = 3'd2,
    ST_FREED        = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_REJECTED     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOCAL,
    S_GLOBAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic sel_global;
    logic commit;
  } spa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reject;
    logic alloc;
    logic found;
  } spa_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/spa_search.sv @@
`default_nettype none

// Next-fit search: first free slot at or after start, wrapping around.
module spa_search #(
  parameter int POOL_SLOTS = spa_pkg::DEF_POOL_SLOTS,
  parameter int PTR_W      = $clog2(POOL_SLOTS)
) (
  input  wire logic [POOL_SLOTS-1:0] used,
  input  wire logic [PTR_W-1:0]      start,
  output logic                       found,
  output logic [PTR_W-1:0]           idx
);

  logic [PTR_W-1:0]      start_c;
  logic [POOL_SLOTS-1:0] free_bits;
  logic [POOL_SLOTS-1:0] hi_mask;
  logic [POOL_SLOTS-1:0] pick;
  logic [POOL_SLOTS-1:0] onehot;

  always_comb begin
    start_c = ({1'b0, start} >= (PTR_W+1)'(POOL_SLOTS)) ? '0 : start;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      hi_mask[i] = (i >= int'(start_c));
    end
    free_bits = ~used;
    pick      = (|(free_bits & hi_mask)) ? (free_bits & hi_mask) : free_bits;
    onehot    = pick & (~pick + {{(POOL_SLOTS-1){1'b0}}, 1'b1});
    idx       = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (onehot[i]) begin
        idx = idx | PTR_W'(i);
      end
    end
    found = |free_bits;
  end

endmodule

`default_nettype wire

@@ rtl/core/spa_ctrl.sv @@
`default_nettype none

module spa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              out_stall,
  input  wire spa_pkg::spa_sts_t sts,
  output spa_pkg::spa_cmd_t      cmd,
  output logic                   in_stall,
  output logic                   out_valid
);

  spa_pkg::state_t state;
  spa_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != spa_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spa_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.commit || (out_valid && out_stall);
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      spa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = spa_pkg::S_LOCAL;
        end
      end
      spa_pkg::S_LOCAL: begin
        // local pool full: fall back to the shared pool
        if (!sts.reject && sts.alloc && !sts.found) begin
          state_next = spa_pkg::S_GLOBAL;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = spa_pkg::S_IDLE;
        end
      end
      spa_pkg::S_GLOBAL: begin
        cmd.sel_global = 1'b1;
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = spa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/spa_dpath.sv @@
`default_nettype none

module spa_dpath #(
  parameter int MAX_CORES        = spa_pkg::DEF_MAX_CORES,
  parameter int POOL_SLOTS       = spa_pkg::DEF_POOL_SLOTS,
  parameter int CORES_PER_SHARED = spa_pkg::DEF_CORES_PER_SHARED
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire spa_pkg::spa_cmd_t            cmd,
  output spa_pkg::spa_sts_t                 sts,
  input  wire logic [spa_pkg::CFG_W-1:0]    active_cores,
  input  wire logic                         opcode,
  input  wire logic [spa_pkg::CORE_W-1:0]   core,
  input  wire logic                         free_global,
  input  wire logic [spa_pkg::FPOOL_W-1:0]  free_pool,
  input  wire logic [spa_pkg::SLOT_W-1:0]   free_slot,
  output logic [spa_pkg::STATUS_W-1:0]      status,
  output logic                              handle_global,
  output logic [spa_pkg::HPOOL_W-1:0]       handle_pool,
  output logic [spa_pkg::SLOT_W-1:0]        handle_slot
);

  localparam int SHARED_POOLS = (MAX_CORES + CORES_PER_SHARED - 1) / CORES_PER_SHARED;
  localparam int LIDX_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int GIDX_W = (SHARED_POOLS > 1) ? $clog2(SHARED_POOLS) : 1;
  localparam int PTR_W  = $clog2(POOL_SLOTS);
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int NCORE  = 2 ** spa_pkg::CORE_W;
  localparam int NFPOOL = 2 ** spa_pkg::FPOOL_W;
  localparam int CIN_W  = spa_pkg::CIN_W;

  typedef struct packed {
    logic [CNT_W-1:0]      cnt;
    logic [PTR_W-1:0]      ptr;
    logic [POOL_SLOTS-1:0] bits;
  } pool_rec_t;

  // constant tables: shared pool of each core, first core of each shared pool
  logic [GIDX_W-1:0] core_pool [NCORE];
  logic [7:0]        pool_base [NFPOOL];

  for (genvar i = 0; i < NCORE; i++) begin : g_core_pool
    assign core_pool[i] = GIDX_W'(i / CORES_PER_SHARED);
  end
  for (genvar i = 0; i < NFPOOL; i++) begin : g_pool_base
    assign pool_base[i] = 8'(i * CORES_PER_SHARED);
  end

  // pool records and their valid bits (invalid reads as empty pool)
  pool_rec_t             local_mem  [MAX_CORES];
  pool_rec_t             global_mem [SHARED_POOLS];
  logic [MAX_CORES-1:0]    local_valid;
  logic [SHARED_POOLS-1:0] global_valid;

  pool_rec_t lrd;
  pool_rec_t grd;
  logic      lvld_q;
  logic      gvld_q;

  // request registers
  logic                       req_alloc;
  logic                       req_fglobal;
  logic                       req_reject;
  logic [spa_pkg::CORE_W-1:0] req_core;
  logic [spa_pkg::SLOT_W-1:0] req_slot;
  logic [LIDX_W-1:0]          req_lidx;
  logic [GIDX_W-1:0]          req_gidx;

  // request decode at accept
  logic [CIN_W-1:0]  cin;
  logic              acc_alloc;
  logic              core_ok;
  logic              slot_ok;
  logic              gpool_ok;
  logic              acc_reject;
  logic [LIDX_W-1:0] acc_lidx;
  logic [GIDX_W-1:0] acc_gidx;

  always_comb begin
    cin = ({1'b0, active_cores} > CIN_W'(MAX_CORES)) ? CIN_W'(MAX_CORES)
                                                     : {1'b0, active_cores};
    acc_alloc  = (opcode == spa_pkg::OP_ALLOC);
    core_ok    = ({2'b00, core} < cin);
    slot_ok    = ({1'b0, free_slot} < CIN_W'(POOL_SLOTS));
    gpool_ok   = ({5'b00000, free_pool} < 8'(SHARED_POOLS))
              && (pool_base[free_pool] < {1'b0, cin});
    acc_reject = !core_ok || (!acc_alloc && (!slot_ok || (free_global && !gpool_ok)));
    acc_lidx   = LIDX_W'(core);
    acc_gidx   = acc_alloc ? core_pool[core] : GIDX_W'(free_pool);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_alloc   <= acc_alloc;
      req_fglobal <= free_global;
      req_reject  <= acc_reject;
      req_core    <= core;
      req_slot    <= free_slot;
      req_lidx    <= acc_lidx;
      req_gidx    <= acc_gidx;
    end
  end

  // work on the selected pool record
  logic                  use_g;
  pool_rec_t             rec;
  logic                  found;
  logic [PTR_W-1:0]      idx;
  logic [PTR_W-1:0]      bitpos;
  logic [POOL_SLOTS-1:0] mask;
  logic                  bit_set;
  logic                  grant;
  logic                  do_write;
  logic                  lwe;
  logic                  gwe;
  pool_rec_t             new_rec;
  spa_pkg::status_t      res_status;

  assign use_g = cmd.sel_global || (!req_alloc && req_fglobal);

  always_comb begin
    if (use_g) begin
      rec = gvld_q ? grd : '0;
    end else begin
      rec = lvld_q ? lrd : '0;
    end
  end

  spa_search #(
    .POOL_SLOTS (POOL_SLOTS),
    .PTR_W      (PTR_W)
  ) u_search (
    .used  (rec.bits),
    .start (rec.ptr),
    .found (found),
    .idx   (idx)
  );

  always_comb begin
    bitpos  = req_alloc ? idx : PTR_W'(req_slot);
    mask    = {{(POOL_SLOTS-1){1'b0}}, 1'b1} << bitpos;
    bit_set = |(rec.bits & mask);
    new_rec = rec;
    if (req_alloc) begin
      new_rec.bits = rec.bits | mask;
      new_rec.ptr  = (idx == PTR_W'(POOL_SLOTS - 1)) ? '0 : idx + PTR_W'(1);
      new_rec.cnt  = rec.cnt + CNT_W'(1);
    end else begin
      new_rec.bits = rec.bits & ~mask;
      new_rec.cnt  = (rec.cnt == '0) ? '0 : rec.cnt - CNT_W'(1);
    end
    grant    = !req_reject && req_alloc && found;
    do_write = cmd.commit && !req_reject && (req_alloc ? found : bit_set);
    lwe      = do_write && !use_g;
    gwe      = do_write && use_g;
    if (req_reject) begin
      res_status = spa_pkg::ST_REJECTED;
    end else if (req_alloc) begin
      if (!found) begin
        res_status = spa_pkg::ST_EXHAUSTED;
      end else if (use_g) begin
        res_status = spa_pkg::ST_GOT_GLOBAL;
      end else begin
        res_status = spa_pkg::ST_GOT_LOCAL;
      end
    end else begin
      res_status = bit_set ? spa_pkg::ST_FREED : spa_pkg::ST_ALREADY_FREE;
    end
  end

  assign sts.reject = req_reject;
  assign sts.alloc  = req_alloc;
  assign sts.found  = found;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (lwe) begin
      local_mem[req_lidx] <= new_rec;
    end
    if (cmd.accept) begin
      lrd    <= local_mem[acc_lidx];
      lvld_q <= local_valid[acc_lidx];
    end
  end

  always_ff @(posedge clk) begin
    if (gwe) begin
      global_mem[req_gidx] <= new_rec;
    end
    if (cmd.accept) begin
      grd    <= global_mem[acc_gidx];
      gvld_q <= global_valid[acc_gidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_valid  <= '0;
      global_valid <= '0;
    end else begin
      if (lwe) begin
        local_valid[req_lidx] <= 1'b1;
      end
      if (gwe) begin
        global_valid[req_gidx] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= res_status;
      handle_global <= grant && use_g;
      if (grant) begin
        handle_pool <= use_g ? spa_pkg::HPOOL_W'(req_gidx) : req_core;
        handle_slot <= spa_pkg::SLOT_W'(idx);
      end else begin
        handle_pool <= '0;
        handle_slot <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/slot_pool_allocator.sv @@
`default_nettype none

// channel  dir  handshake              payload
// in       in   in_valid / in_stall    opcode, core, free_global, free_pool, free_slot
// out      out  out_valid / out_stall  status, handle_global, handle_pool, handle_slot
// cfg      in   APB psel/penable       active_cores at byte address 0
//
// Local alloc and free: pool record read at accept, then search and write-back in
// S_LOCAL. Shared-pool fallback adds S_GLOBAL, a second search on the shared record.
// Synchronous reset clears the pool valid bits; every pool then reads empty at once.
// in_stall is high while a request is in flight; a stalled result holds in the
// output register and the next request is still taken behind it.
module slot_pool_allocator #(
  parameter int MAX_CORES        = spa_pkg::DEF_MAX_CORES,
  parameter int POOL_SLOTS       = spa_pkg::DEF_POOL_SLOTS,
  parameter int CORES_PER_SHARED = spa_pkg::DEF_CORES_PER_SHARED
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         opcode,
  input  wire logic [spa_pkg::CORE_W-1:0]   core,
  input  wire logic                         free_global,
  input  wire logic [spa_pkg::FPOOL_W-1:0]  free_pool,
  input  wire logic [spa_pkg::SLOT_W-1:0]   free_slot,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [spa_pkg::STATUS_W-1:0]      status,
  output logic                              handle_global,
  output logic [spa_pkg::HPOOL_W-1:0]       handle_pool,
  output logic [spa_pkg::SLOT_W-1:0]        handle_slot,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spa_pkg::APB_AW-1:0]   paddr,
  input  wire logic [spa_pkg::APB_DW-1:0]   pwdata,
  output logic [spa_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam logic REG_ACTIVE_CORES = 1'b0;

  logic [spa_pkg::CFG_W-1:0] active_cores;
  spa_pkg::spa_cmd_t         cmd;
  spa_pkg::spa_sts_t         sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cores <= spa_pkg::CFG_W'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_CORES)) begin
      active_cores <= pwdata[spa_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACTIVE_CORES) begin
      prdata = {{(spa_pkg::APB_DW - spa_pkg::CFG_W){1'b0}}, active_cores};
    end
  end

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  spa_dpath #(
    .MAX_CORES        (MAX_CORES),
    .POOL_SLOTS       (POOL_SLOTS),
    .CORES_PER_SHARED (CORES_PER_SHARED)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .active_cores  (active_cores),
    .opcode        (opcode),
    .core          (core),
    .free_global   (free_global),
    .free_pool     (free_pool),
    .free_slot     (free_slot),
    .status        (status),
    .handle_global (handle_global),
    .handle_pool   (handle_pool),
    .handle_slot   (handle_slot)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while another is in flight");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled result");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != spa_pkg::ST_GOT_LOCAL && status != spa_pkg::ST_GOT_GLOBAL)
    |-> (!handle_global && handle_pool == '0 && handle_slot == '0))
    else $error("handle set on a non-grant result");

  a_handle_global: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (handle_global == (status == spa_pkg::ST_GOT_GLOBAL)))
    else $error("handle_global disagrees with status");

endmodule

`default_nettype wire
